FILE: hw/rtl/valid_conv2d_scaled_macros.svh
// assertion macros for the valid_conv2d_scaled block
// used by the queue and back-end modules; relies on clk and rst_n in scope
`ifndef VALID_CONV2D_SCALED_MACROS_SVH
`define VALID_CONV2D_SCALED_MACROS_SVH

// same-cycle implication
`define VC2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vc2d assertion failed");

// next-cycle implication
`define VC2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vc2d assertion failed");

`endif

FILE: hw/rtl/vc2d_pkg.sv
// shared types and constants for the valid_conv2d_scaled block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vc2d_pkg;

    // default sizes
    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 64;

    // queue entry field widths, sized for the full parameter range
    localparam int COL_FW   = 10;
    localparam int SLOT_FW  = 3;
    localparam int QUEUE_DEPTH = 2;

    // fixed field widths
    localparam int PIX_W   = 16;
    localparam int CIDX_W  = 5;
    localparam int KS_W    = 3;
    localparam int IW_W    = 7;
    localparam int IH_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int RES_W   = 32;
    localparam int SCALE_SHIFT = 26;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 2'd3;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic                   is_pixel;
        logic [CIDX_W-1:0]      cidx;
        logic [PIX_W-1:0]       data;
        logic [COL_FW-1:0]      col;
        logic [SLOT_FW-1:0]     slot;
        logic [COL_FW-1:0]      col0;
        logic [SLOT_FW-1:0]     slot0;
        logic                   produce;
        logic                   last;
    } item_t;

    // back-end sequencer
    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_ADDR,
        B_MUL,
        B_ACC,
        B_SCALE,
        B_SAT
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vc2d_front.sv
// front end: accepts transactions, tracks pixel position, classifies windows
// depends on vc2d_pkg
`timescale 1ns / 1ps
`default_nettype none

module vc2d_front #(
    parameter int MAX_KERNEL = vc2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = vc2d_pkg::MAX_WIDTH_DEF,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int W_W    = $clog2(MAX_WIDTH + 1),
    localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_op,
    input  wire logic [vc2d_pkg::CIDX_W-1:0] in_cidx,
    input  wire logic [vc2d_pkg::PIX_W-1:0]  in_coeff,
    input  wire logic [vc2d_pkg::PIX_W-1:0]  in_pixel,
    output logic                           in_ready,
    input  wire logic                      restart,
    input  wire logic [vc2d_pkg::KS_W-1:0]   k_eff,
    input  wire logic [W_W-1:0]            w_eff,
    input  wire logic [vc2d_pkg::IH_W-1:0]   h_eff,
    input  wire logic                      q_full,
    output logic                           q_push,
    output vc2d_pkg::item_t                q_item
);

    logic [COL_W-1:0]            col_reg, col_next;
    logic [vc2d_pkg::IH_W-1:0]   row_reg, row_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [W_W-1:0]              c;
    logic [W_W:0]                c1;
    logic [vc2d_pkg::IH_W:0]     r1;
    logic [3:0]                  km1;
    logic [3:0]                  s0;
    logic                        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    // clamp the column and form window bounds
    always_comb
    begin
        c   = (W_W'(col_reg) >= w_eff) ? (w_eff - W_W'(1)) : W_W'(col_reg);
        c1  = {1'b0, c} + (W_W+1)'(1);
        r1  = {1'b0, row_reg} + (vc2d_pkg::IH_W+1)'(1);
        km1 = 4'(k_eff) - 4'd1;
        if (4'(slot_reg) >= km1)
            s0 = 4'(slot_reg) - km1;
        else
            s0 = 4'(slot_reg) + 4'(MAX_KERNEL) - km1;
    end

    // build the queue entry
    always_comb
    begin
        q_item.is_pixel = in_op;
        q_item.cidx     = in_cidx;
        q_item.data     = in_op ? in_pixel : in_coeff;
        q_item.col      = vc2d_pkg::COL_FW'(c);
        q_item.slot     = vc2d_pkg::SLOT_FW'(slot_reg);
        q_item.col0     = vc2d_pkg::COL_FW'(c - W_W'(km1));
        q_item.slot0    = vc2d_pkg::SLOT_FW'(s0);
        q_item.produce  = (r1 >= (vc2d_pkg::IH_W+1)'(k_eff)) && (c1 >= (W_W+1)'(k_eff))
                          && (row_reg < h_eff);
        q_item.last     = (r1 >= {1'b0, h_eff}) && (c1 >= {1'b0, w_eff});
    end

    // position update
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
        end
        else if (accept && in_op)
        begin
            if (c1 >= {1'b0, w_eff})
            begin
                col_next = '0;
                if (r1 >= {1'b0, h_eff})
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + vc2d_pkg::IH_W'(1);
                    slot_next = (int'(slot_reg) == MAX_KERNEL - 1) ? '0
                                : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = COL_W'(c1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vc2d_queue.sv
// two-entry queue between front and back ends
// depends on vc2d_pkg and valid_conv2d_scaled_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "valid_conv2d_scaled_macros.svh"

module vc2d_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire vc2d_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output vc2d_pkg::item_t      head
);

    localparam int PTR_W = $clog2(vc2d_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vc2d_pkg::QUEUE_DEPTH + 1);

    vc2d_pkg::item_t   store_reg [vc2d_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(vc2d_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = store_reg[rd_reg];

    // pointer and count update
    always_comb
    begin
        wr_next  = push ? ((int'(wr_reg) == vc2d_pkg::QUEUE_DEPTH - 1) ? '0
                   : wr_reg + PTR_W'(1)) : wr_reg;
        rd_next  = pop ? ((int'(rd_reg) == vc2d_pkg::QUEUE_DEPTH - 1) ? '0
                   : rd_reg + PTR_W'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_reg] <= push_item;
    end

    `VC2D_ASSERT_NOW(a_no_push_full, push, !full)
    `VC2D_ASSERT_NOW(a_no_pop_empty, pop, valid)

endmodule

`default_nettype wire

FILE: hw/rtl/vc2d_back.sv
// back end: line store, coefficient store, sequential multiply-accumulate, scaling
// depends on vc2d_pkg and valid_conv2d_scaled_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "valid_conv2d_scaled_macros.svh"

module vc2d_back #(
    parameter int MAX_KERNEL = vc2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = vc2d_pkg::MAX_WIDTH_DEF,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire vc2d_pkg::item_t            q_item,
    output logic                            q_pop,
    input  wire logic [vc2d_pkg::KS_W-1:0]  k_eff,
    input  wire logic [vc2d_pkg::PIX_W-1:0] scale,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [vc2d_pkg::RES_W-1:0]      out_value,
    output logic                            out_last
);

    localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int TAP_W  = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int ACC_W  = 2 * vc2d_pkg::PIX_W + $clog2(CDEPTH) + 1;
    localparam int SP_W   = ACC_W + vc2d_pkg::PIX_W;
    localparam logic signed [SP_W-1:0] SAT_HI = SP_W'(64'sd2147483647);
    localparam logic signed [SP_W-1:0] SAT_LO = -SAT_HI - SP_W'(1);

    vc2d_pkg::back_state_t          state_reg, state_next;
    vc2d_pkg::item_t                item_reg;

    logic [vc2d_pkg::PIX_W-1:0]     coeff_reg [CDEPTH];
    logic [vc2d_pkg::PIX_W-1:0]     line_mem  [LDEPTH];

    logic [vc2d_pkg::KS_W-1:0]      kr_reg, kc_reg;
    logic [TAP_W-1:0]               tap_reg;
    logic [SLOT_W-1:0]              srow_reg;
    logic [COL_W-1:0]               scol_reg;
    logic [vc2d_pkg::PIX_W-1:0]     pix_q_reg;
    logic [vc2d_pkg::PIX_W-1:0]     coef_q_reg;
    logic signed [2*vc2d_pkg::PIX_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SP_W-1:0]         sprod_reg;
    logic signed [SP_W-1:0]         shifted;
    logic [LA_W-1:0]                wr_addr, rd_addr;
    logic                           last_tap;
    logic                           out_free;
    logic [vc2d_pkg::RES_W-1:0]     sat_value;

    assign wr_addr  = LA_W'(int'(item_reg.slot[SLOT_W-1:0]) * MAX_WIDTH
                      + int'(item_reg.col[COL_W-1:0]));
    assign rd_addr  = LA_W'(int'(srow_reg) * MAX_WIDTH + int'(scol_reg));
    assign last_tap = (kr_reg == k_eff - vc2d_pkg::KS_W'(1))
                      && (kc_reg == k_eff - vc2d_pkg::KS_W'(1));
    assign out_free = !out_valid || out_ready;
    assign shifted  = sprod_reg >>> vc2d_pkg::SCALE_SHIFT;

    // saturate to 32 bits
    always_comb
    begin
        if (shifted > SAT_HI)
            sat_value = vc2d_pkg::RES_W'(SAT_HI);
        else if (shifted < SAT_LO)
            sat_value = vc2d_pkg::RES_W'(SAT_LO);
        else
            sat_value = vc2d_pkg::RES_W'(shifted);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            vc2d_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = vc2d_pkg::B_WRITE;
                end
            end
            vc2d_pkg::B_WRITE:
                state_next = (item_reg.is_pixel && item_reg.produce) ? vc2d_pkg::B_ADDR
                             : vc2d_pkg::B_IDLE;
            vc2d_pkg::B_ADDR:
                state_next = vc2d_pkg::B_MUL;
            vc2d_pkg::B_MUL:
                state_next = vc2d_pkg::B_ACC;
            vc2d_pkg::B_ACC:
                state_next = last_tap ? vc2d_pkg::B_SCALE : vc2d_pkg::B_ADDR;
            vc2d_pkg::B_SCALE:
                state_next = vc2d_pkg::B_SAT;
            vc2d_pkg::B_SAT:
                state_next = out_free ? vc2d_pkg::B_IDLE : vc2d_pkg::B_SAT;
            default:
                state_next = vc2d_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vc2d_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    // tap counters and datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        if (state_reg == vc2d_pkg::B_WRITE)
        begin
            kr_reg   <= '0;
            kc_reg   <= '0;
            tap_reg  <= '0;
            srow_reg <= item_reg.slot0[SLOT_W-1:0];
            scol_reg <= item_reg.col0[COL_W-1:0];
            acc_reg  <= '0;
        end
        if (state_reg == vc2d_pkg::B_MUL)
            prod_reg <= $signed(coef_q_reg) * $signed(pix_q_reg);
        if (state_reg == vc2d_pkg::B_ACC)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
            tap_reg <= tap_reg + TAP_W'(1);
            if (kc_reg == k_eff - vc2d_pkg::KS_W'(1))
            begin
                kc_reg   <= '0;
                kr_reg   <= kr_reg + vc2d_pkg::KS_W'(1);
                scol_reg <= item_reg.col0[COL_W-1:0];
                srow_reg <= (int'(srow_reg) == MAX_KERNEL - 1) ? '0
                            : srow_reg + SLOT_W'(1);
            end
            else
            begin
                kc_reg   <= kc_reg + vc2d_pkg::KS_W'(1);
                scol_reg <= scol_reg + COL_W'(1);
            end
        end
        if (state_reg == vc2d_pkg::B_SCALE)
            sprod_reg <= SP_W'(acc_reg) * SP_W'($signed(scale));
    end

    // line store, written in the write state, then read one tap per address state
    always_ff @(posedge clk)
    begin
        if (state_reg == vc2d_pkg::B_WRITE && item_reg.is_pixel)
            line_mem[wr_addr] <= item_reg.data;
        if (state_reg == vc2d_pkg::B_ADDR)
            pix_q_reg <= line_mem[rd_addr];
    end

    // coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CDEPTH; i++)
                coeff_reg[i] <= '0;
        end
        else if (state_reg == vc2d_pkg::B_WRITE && !item_reg.is_pixel
                 && int'(item_reg.cidx) < CDEPTH)
        begin
            coeff_reg[TAP_W'(item_reg.cidx)] <= item_reg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vc2d_pkg::B_ADDR)
            coef_q_reg <= coeff_reg[tap_reg];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_reg == vc2d_pkg::B_SAT && out_free)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == vc2d_pkg::B_SAT && out_free)
        begin
            out_value <= sat_value;
            out_last  <= item_reg.last;
        end
    end

    `VC2D_ASSERT_NOW(a_pop_idle, q_pop, state_reg == vc2d_pkg::B_IDLE)
    `VC2D_ASSERT_NEXT(a_result_loaded, state_reg == vc2d_pkg::B_SAT && out_free, out_valid)
    `VC2D_ASSERT_NOW(a_tap_range, state_reg == vc2d_pkg::B_ADDR, int'(tap_reg) < CDEPTH)

endmodule

`default_nettype wire

FILE: hw/rtl/valid_conv2d_scaled.sv
// valid-region 2d convolution: front end, two-entry queue, sequential MAC back end.
// a coefficient or a pixel without a result passes the back end's idle and write states;
// a pixel with a result then loops address, multiply, accumulate per tap (one shared
// multiplier, one line store read per tap); m_tvalid is registered from the saturate
// state after scaling. a new item is taken only when the back end is idle; reset clears
// position, coefficients, registers to defaults; line store needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module valid_conv2d_scaled #(
    parameter int MAX_KERNEL = vc2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = vc2d_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // fields from bit 0: coeff_index[4:0], coeff_value[20:5], pixel_value[36:21]
    input  wire logic [39:0] s_tdata,
    // fields from bit 0: operation
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fields from bit 0: conv_value[31:0]
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [vc2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vc2d_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int W_W = $clog2(MAX_WIDTH + 1);

    logic [vc2d_pkg::KS_W-1:0]  ks_reg;
    logic [vc2d_pkg::IW_W-1:0]  iw_reg;
    logic [vc2d_pkg::IH_W-1:0]  ih_reg;
    logic [vc2d_pkg::PIX_W-1:0] scale_reg;
    logic [vc2d_pkg::KS_W-1:0]  k_eff;
    logic [W_W-1:0]             w_eff;
    logic [vc2d_pkg::IH_W-1:0]  h_eff;
    logic                       cfg_wr;
    logic                       restart;
    logic                       q_full, q_push, q_pop, q_valid;
    vc2d_pkg::item_t            push_item, head_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index != vc2d_pkg::REG_OUTPUT_SCALE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg    <= vc2d_pkg::KS_W'(3);
            iw_reg    <= vc2d_pkg::IW_W'(64);
            ih_reg    <= vc2d_pkg::IH_W'(64);
            scale_reg <= vc2d_pkg::PIX_W'(4096);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                vc2d_pkg::REG_KERNEL_SIZE:  ks_reg    <= cfg_data[vc2d_pkg::KS_W-1:0];
                vc2d_pkg::REG_IMAGE_WIDTH:  iw_reg    <= cfg_data[vc2d_pkg::IW_W-1:0];
                vc2d_pkg::REG_IMAGE_HEIGHT: ih_reg    <= cfg_data[vc2d_pkg::IH_W-1:0];
                vc2d_pkg::REG_OUTPUT_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb
    begin
        if (ks_reg == '0)
            k_eff = vc2d_pkg::KS_W'(1);
        else if (int'(ks_reg) > MAX_KERNEL)
            k_eff = vc2d_pkg::KS_W'(MAX_KERNEL);
        else
            k_eff = ks_reg;
        if (iw_reg == '0)
            w_eff = W_W'(1);
        else if (int'(iw_reg) > MAX_WIDTH)
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(iw_reg);
        h_eff = (ih_reg == '0) ? vc2d_pkg::IH_W'(1) : ih_reg;
    end

    vc2d_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_cidx  (s_tdata[4:0]),
        .in_coeff (s_tdata[20:5]),
        .in_pixel (s_tdata[36:21]),
        .in_ready (s_tready),
        .restart  (restart),
        .k_eff    (k_eff),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    vc2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    vc2d_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .k_eff     (k_eff),
        .scale     (scale_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
